@@ src/i2a_pkg.sv @@
// ----------------------------------------------------------------------------
// i2a_pkg
// Types and constants for the signed 32-bit integer to decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned CHAR_W    = 6;
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned BCD_W     = 4 * NUM_DIGITS;

    // ascii codes, trimmed to six bits
    localparam logic [CHAR_W-1:0] C_CHAR_MINUS = 6'd45;
    localparam logic [1:0]        C_DIGIT_HI   = 2'b11;   // '0' is 6'b11_0000

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SIGN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    // double-dabble correction of one bcd digit before the shift
    function automatic logic [3:0] f_add3(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? 4'(d + 4'd3) : d;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/int32_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii
// Converts one signed 32-bit integer into its decimal ascii text, one
// character per beat, sign first, most significant digit next.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. Its magnitude is turned
// into ten bcd digits by a bit-serial shift-and-add-3 pass, one magnitude bit
// per cycle. Then a '-' beat follows for a negative value, and a scan over
// the bcd register walks the ten digits from the top, one per cycle: leading
// zeros are dropped silently, every other digit leaves as one beat. Busy
// stays high through the conversion, the sign beat and the digit scan, so a
// new value is taken only after the previous one has been fully converted and
// scanned. The final digit leaves in the first cycle in which busy is low,
// and the next value can already be taken in that cycle.
// Each character appears on o_character for exactly one cycle, marked by
// o_strobe, with o_last high on the final digit; the receiver cannot stall
// the block, so it must take every beat as it comes. Zero gives the single
// character '0', and the most negative value gives "-2147483648".
// ----------------------------------------------------------------------------
`default_nettype none

module int32_to_decimal_ascii
    import i2a_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output      logic                      busy,
    input  wire logic signed [VALUE_W-1:0] i_value,
    output      logic                      o_strobe,
    output      logic [CHAR_W-1:0]         o_character,
    output      logic                      o_last
);

    // control state
    t_state r_state, n_state;
    logic [4:0] r_bit_cnt, n_bit_cnt;     // magnitude bits shifted so far
    logic [3:0] r_dig_cnt, n_dig_cnt;     // digits still in the bcd register
    logic       r_lead, n_lead;           // still in the leading zeros
    logic       r_strobe, n_strobe;

    // datapath
    logic [VALUE_W-1:0] r_mag, n_mag;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic               r_neg, n_neg;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;

    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         top_digit;
    logic               skip_digit;

    // add-3 on every digit in parallel, digits are independent
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            bcd_adj[4*k +: 4] = f_add3(r_bcd[4*k +: 4]);
        end
    end

    assign top_digit  = r_bcd[BCD_W-1 -: 4];
    assign skip_digit = r_lead && (top_digit == 4'd0) && (r_dig_cnt != 4'd1);

    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        n_dig_cnt = r_dig_cnt;
        n_lead    = r_lead;
        n_strobe  = 1'b0;
        n_mag     = r_mag;
        n_bcd     = r_bcd;
        n_neg     = r_neg;
        n_char    = r_char;
        n_last    = r_last;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_neg     = i_value[VALUE_W-1];
                    // unsigned negate, so the most negative value stays right
                    n_mag     = i_value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(i_value))
                                                   : $unsigned(i_value);
                    n_bcd     = '0;
                    n_bit_cnt = '0;
                    n_state   = ST_CONV;
                end
            end
            ST_CONV: begin
                {n_bcd, n_mag} = {bcd_adj, r_mag} << 1;
                n_bit_cnt      = r_bit_cnt + 5'd1;
                if (r_bit_cnt == 5'(VALUE_W - 1)) begin
                    n_dig_cnt = 4'(NUM_DIGITS);
                    n_lead    = 1'b1;
                    n_state   = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                n_strobe = 1'b1;
                n_char   = C_CHAR_MINUS;
                n_last   = 1'b0;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                n_bcd     = r_bcd << 4;
                n_dig_cnt = r_dig_cnt - 4'd1;
                if (!skip_digit) begin
                    n_lead   = 1'b0;
                    n_strobe = 1'b1;
                    n_char   = {C_DIGIT_HI, top_digit};
                    n_last   = (r_dig_cnt == 4'd1);
                end
                if (r_dig_cnt == 4'd1) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bit_cnt <= '0;
            r_dig_cnt <= '0;
            r_lead    <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
            r_dig_cnt <= n_dig_cnt;
            r_lead    <= n_lead;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;

    // a value's last beat is never followed directly by another beat
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("beat right after last");

    // no beat leaves while the bit-serial conversion runs
    a_conv_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !o_strobe)
        else $error("beat during conversion");

    // the minus sign is never the final character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_character == C_CHAR_MINUS) |-> !o_last)
        else $error("minus flagged last");

    // every character is a minus sign or a decimal digit
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_character == C_CHAR_MINUS) ||
                     ((o_character[5:4] == C_DIGIT_HI) && (o_character[3:0] <= 4'd9)))
        else $error("illegal character");

endmodule

`default_nettype wire
